/* src/fcct_pkg.sv */
// shared types and constants for the five channel compare timer unit
package fcct_pkg;

  localparam int NumTimersDef = 5;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActRead  = 2'd1,
    ActWrite = 2'd2,
    ActNop   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OffCtrl  = 4'd0,
    OffIoc   = 4'd1,
    OffIer   = 4'd2,
    OffFlags = 4'd3,
    OffCntH  = 4'd4,
    OffCntL  = 4'd5,
    OffCmaH  = 4'd6,
    OffCmaL  = 4'd7,
    OffCmbH  = 4'd8,
    OffCmbL  = 4'd9,
    OffNone  = 4'd15
  } reg_off_e;

  // decoded register address
  typedef struct packed {
    logic       common;
    logic [2:0] timer;
    reg_off_e   off;
    logic [1:0] common_off;
  } addr_dec_t;

  // per timer state
  typedef struct packed {
    logic [6:0]  ctrl;
    logic [7:0]  ier;
    logic [2:0]  flags;
    logic [15:0] cnt;
    logic [15:0] cma;
    logic [15:0] cmb;
    logic [2:0]  phase;
  } timer_state_t;

  function automatic addr_dec_t decode_addr(input logic [5:0] a);
    addr_dec_t d;
    logic [5:0] x;
    d.common = 1'b0;
    d.timer = 3'd0;
    d.off = OffNone;
    d.common_off = 2'd3;
    x = 6'd0;
    if (a >= 6'h32) begin
      x = a - 6'h32;
      d.timer = 3'd4;
      d.off = (x < 6'd10) ? reg_off_e'(x[3:0]) : OffNone;
    end else if (a >= 6'h22 && a < 6'h30) begin
      x = a - 6'h22;
      d.timer = 3'd3;
      d.off = (x < 6'd10) ? reg_off_e'(x[3:0]) : OffNone;
    end else if (a >= 6'h18 && a < 6'h22) begin
      d.timer = 3'd2;
      d.off = reg_off_e'(4'(a - 6'h18));
    end else if (a >= 6'h0e && a < 6'h18) begin
      d.timer = 3'd1;
      d.off = reg_off_e'(4'(a - 6'h0e));
    end else if (a >= 6'h04 && a < 6'h0e) begin
      d.timer = 3'd0;
      d.off = reg_off_e'(4'(a - 6'h04));
    end else begin
      d.common = 1'b1;
      // only the first three addresses hold common registers
      d.common_off = (a < 6'h04) ? a[1:0] : 2'd3;
    end
    return d;
  endfunction

endpackage

/* src/fcct_channel.sv */
// one timer channel: register writes, prescaler, counter and compare match
module fcct_channel import fcct_pkg::*; (
  input  timer_state_t cur_i,
  input  logic         run_i,
  input  logic         start_i,
  input  logic         tick_i,
  input  logic         wr_i,
  input  reg_off_e     off_i,
  input  logic [7:0]   data_i,
  input  logic         dma_cap_i,
  output timer_state_t nxt_o,
  output logic         dma_o
);

  logic        restart;
  logic [3:0]  ph;
  logic [16:0] n;
  logic        hit_a, hit_b, clr, step;
  timer_state_t s;

  always_comb begin
    s = cur_i;
    restart = start_i;
    dma_o = 1'b0;
    ph = 4'd0;
    n = 17'd0;
    hit_a = 1'b0;
    hit_b = 1'b0;
    clr = 1'b0;
    step = 1'b0;
    if (wr_i) begin
      case (off_i)
        OffCtrl:  begin s.ctrl = data_i[6:0]; restart = run_i; end
        OffIer:   s.ier = data_i;
        OffFlags: s.flags = s.flags & data_i[2:0];
        OffCntH:  begin s.cnt[15:8] = data_i; restart = run_i; end
        OffCntL:  begin s.cnt[7:0] = data_i; restart = run_i; end
        OffCmaH:  begin s.cma[15:8] = data_i; restart = run_i; end
        OffCmaL:  begin s.cma[7:0] = data_i; restart = run_i; end
        OffCmbH:  begin s.cmb[15:8] = data_i; restart = run_i; end
        OffCmbL:  begin s.cmb[7:0] = data_i; restart = run_i; end
        default:  ;
      endcase
    end
    if (restart) begin
      s.phase = 3'd0;
      if (s.ctrl[6:5] == 2'd3) s.ctrl[6:5] = 2'd0;
    end
    if (tick_i && run_i) begin
      ph = {1'b0, s.phase} + 4'd1;
      step = ph >= (4'd1 << s.ctrl[1:0]);
      s.phase = step ? 3'd0 : ph[2:0];
      if (step) begin
        n = {1'b0, s.cnt} + 17'd1;
        hit_a = (s.cma != 16'd0) && (n[15:0] == s.cma) && !n[16];
        hit_b = (s.cmb != 16'd0) && (n[15:0] == s.cmb) && !n[16];
        if (hit_a) begin
          s.flags[0] = 1'b1;
          dma_o = dma_cap_i & s.ier[0];
          if (s.ctrl[6:5] == 2'd1) clr = 1'b1;
        end
        if (hit_b) begin
          s.flags[1] = 1'b1;
          if (s.ctrl[6:5] == 2'd2) clr = 1'b1;
        end
        if (n[16]) s.flags[2] = 1'b1;
        s.cnt = clr ? 16'd0 : n[15:0];
      end
    end
    nxt_o = s;
  end

endmodule

/* src/five_channel_compare_timer_unit.sv */
// top level of the five channel compare timer unit
// Each transaction is a tick, a byte read or a byte write; one result comes out per
// transaction, in the cycle after acceptance, and a new transaction is taken every clock
// as long as the result register is free or being drained. All five channels update
// in parallel in the combinational logic between the input and the result register.
module five_channel_compare_timer_unit import fcct_pkg::*; #(
  parameter int NumTimers = NumTimersDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [5:0] reg_addr_i,
  input  logic [7:0] write_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic [4:0] irq_active_o,
  output logic [1:0] irq_source_t0_o,
  output logic [1:0] irq_source_t1_o,
  output logic [1:0] irq_source_t2_o,
  output logic [1:0] irq_source_t3_o,
  output logic [1:0] irq_source_t4_o,
  output logic [3:0] dma_pulse_o
);

  timer_state_t tmr_q [NumTimers];
  timer_state_t tmr_d [NumTimers];
  logic [NumTimers-1:0] run_q, run_d, dma;
  logic [4:0] sync_q, sync_d;
  logic [6:0] mode_q, mode_d;
  logic       acc, is_tick, is_rd, is_wr;
  addr_dec_t  dec;
  logic [7:0] rd;
  logic [1:0] src [NumTimers];
  logic [NumTimers-1:0] act;

  assign in_stall_o = out_valid_o & out_stall_i;
  assign acc = in_valid_i & ~in_stall_o;
  assign is_tick = acc && action_e'(action_i) == ActTick;
  assign is_rd = acc && action_e'(action_i) == ActRead;
  assign is_wr = acc && action_e'(action_i) == ActWrite;
  assign dec = decode_addr(reg_addr_i);

  always_comb begin
    run_d = run_q;
    sync_d = sync_q;
    mode_d = mode_q;
    if (is_wr && dec.common) begin
      case (dec.common_off)
        2'd0: run_d = write_byte_i[NumTimers-1:0];
        2'd1: sync_d = write_byte_i[4:0];
        2'd2: mode_d = write_byte_i[6:0];
        default: ;
      endcase
    end
  end

  for (genvar t = 0; t < NumTimers; t++) begin : g_ch
    fcct_channel u_ch (
      .cur_i    (tmr_q[t]),
      .run_i    (run_q[t]),
      .start_i  (run_d[t] & ~run_q[t]),
      .tick_i   (is_tick),
      .wr_i     (is_wr && !dec.common && dec.timer == 3'(t)),
      .off_i    (dec.off),
      .data_i   (write_byte_i),
      .dma_cap_i(t < 4 ? 1'b1 : 1'b0),
      .nxt_o    (tmr_d[t]),
      .dma_o    (dma[t])
    );
  end

  always_comb begin
    rd = 8'd0;
    if (dec.common) begin
      case (dec.common_off)
        2'd0: rd = 8'h60 | 8'(run_q);
        2'd1: rd = 8'h60 | {3'd0, sync_q};
        2'd2: rd = {1'b0, mode_q};
        default: rd = 8'd0;
      endcase
    end else begin
      case (dec.off)
        OffCtrl:  rd = {1'b0, tmr_q[dec.timer].ctrl};
        OffIer:   rd = tmr_q[dec.timer].ier;
        OffFlags: rd = {5'b01111, tmr_q[dec.timer].flags};
        OffCntH:  rd = tmr_q[dec.timer].cnt[15:8];
        OffCntL:  rd = tmr_q[dec.timer].cnt[7:0];
        OffCmaH:  rd = tmr_q[dec.timer].cma[15:8];
        OffCmaL:  rd = tmr_q[dec.timer].cma[7:0];
        OffCmbH:  rd = tmr_q[dec.timer].cmb[15:8];
        OffCmbL:  rd = tmr_q[dec.timer].cmb[7:0];
        default:  rd = 8'd0;
      endcase
    end
    if (!is_rd) rd = 8'd0;
  end

  always_comb begin
    for (int t = 0; t < NumTimers; t++) begin
      logic [2:0] p;
      p = tmr_d[t].ier[2:0] & tmr_d[t].flags;
      act[t] = |p;
      src[t] = p[0] ? 2'd0 : (p[1] ? 2'd1 : (p[2] ? 2'd2 : 2'd0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      sync_q <= '0;
      mode_q <= '0;
      out_valid_o <= 1'b0;
      for (int t = 0; t < NumTimers; t++) tmr_q[t] <= '0;
    end else begin
      if (acc) begin
        run_q <= run_d;
        sync_q <= sync_d;
        mode_q <= mode_d;
        for (int t = 0; t < NumTimers; t++) tmr_q[t] <= tmr_d[t];
      end
      if (acc) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      read_byte_o <= rd;
      irq_active_o <= 5'(act);
      irq_source_t0_o <= src[0];
      irq_source_t1_o <= src[1];
      irq_source_t2_o <= src[2];
      irq_source_t3_o <= src[3];
      irq_source_t4_o <= src[4];
      dma_pulse_o <= is_tick ? dma[3:0] : 4'd0;
    end
  end

  a_dma_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !is_tick |=> dma_pulse_o == 4'd0) else $error("dma pulse outside tick");
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !is_rd |=> read_byte_o == 8'd0) else $error("read data outside read");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(run_q) && $stable(mode_q)) else $error("state moved without transaction");

endmodule
